### src/temp_limit_command_parser_defines.svh
// Assertion macros shared by the temperature limit command parser RTL.
`ifndef TEMP_LIMIT_COMMAND_PARSER_DEFINES_SVH
`define TEMP_LIMIT_COMMAND_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TLCP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("tlcp: implication check failed");

// Next-cycle implication, checked outside reset.
`define TLCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("tlcp: next-cycle check failed");

`endif

### src/tlcp_pkg.sv
// Package for the temperature limit command parser: types, codes and keyword tables.
package tlcp_pkg;

  localparam int LINE_CAPACITY = 64;
  localparam int LEN_W         = $clog2(LINE_CAPACITY);
  localparam int DATA_W        = 8;
  localparam int VAL_W         = 15;
  localparam int KIDX_W        = 4;
  localparam int KW_LEN        = 12;

  localparam logic [VAL_W-1:0] VALUE_MAX     = 15'd32767;
  localparam logic [VAL_W-1:0] MAX_RESET_VAL = 15'd270;
  localparam logic [VAL_W-1:0] MIN_RESET_VAL = 15'd100;

  localparam logic [DATA_W-1:0] CH_CR    = 8'h0D;
  localparam logic [DATA_W-1:0] CH_LF    = 8'h0A;
  localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;
  localparam logic [DATA_W-1:0] CH_TAB   = 8'h09;
  localparam logic [DATA_W-1:0] CH_NUL   = 8'h00;
  localparam logic [DATA_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [DATA_W-1:0] CH_NINE  = 8'h39;

  // Candidate bits: bit 0 max keyword, bit 1 min keyword
  localparam logic [1:0] CAND_BOTH = 2'b11;

  typedef enum logic [1:0] {
    ST_MAX_SET  = 2'd0,
    ST_MIN_SET  = 2'd1,
    ST_UNKNOWN  = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_KEY    = 3'd1,
    PH_SEP    = 3'd2,
    PH_GAP    = 3'd3,
    PH_DIGITS = 3'd4,
    PH_TRAIL  = 3'd5,
    PH_FAIL   = 3'd6
  } phase_t;

  typedef struct packed {
    status_t            status;
    logic [VAL_W-1:0]   value;
    logic [VAL_W-1:0]   max_limit;
    logic [VAL_W-1:0]   min_limit;
  } result_t;

  // Per-keyword match of one byte at a keyword position
  function automatic logic [1:0] kw_match(input logic [KIDX_W-1:0] idx,
                                          input logic [DATA_W-1:0] c);
    logic [DATA_W-1:0] ch_max;
    logic [DATA_W-1:0] ch_min;
    ch_max = 8'h00;
    ch_min = 8'h00;
    unique case (idx)
      4'd0:    begin ch_max = "S"; ch_min = "S"; end
      4'd1:    begin ch_max = "E"; ch_min = "E"; end
      4'd2:    begin ch_max = "T"; ch_min = "T"; end
      4'd3:    begin ch_max = "_"; ch_min = "_"; end
      4'd4:    begin ch_max = "M"; ch_min = "M"; end
      4'd5:    begin ch_max = "A"; ch_min = "I"; end
      4'd6:    begin ch_max = "X"; ch_min = "N"; end
      4'd7:    begin ch_max = "_"; ch_min = "_"; end
      4'd8:    begin ch_max = "T"; ch_min = "T"; end
      4'd9:    begin ch_max = "E"; ch_min = "E"; end
      4'd10:   begin ch_max = "M"; ch_min = "M"; end
      4'd11:   begin ch_max = "P"; ch_min = "P"; end
      default: begin ch_max = 8'h00; ch_min = 8'h00; end
    endcase
    return {(ch_min == c), (ch_max == c)};
  endfunction

  function automatic logic is_blank(input logic [DATA_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_digit(input logic [DATA_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

### src/temp_limit_command_parser.sv
// Temperature limit command parser: line parser, threshold registers and output queue.
//
// Usage notes:
//   Input channel (in_valid / in_stall / in_rx_data) takes one received byte per item.
//   A line holding the max or min keyword, a blank and a number n <= 32767, with
//   optional blanks around them, ends in CR or LF and updates the matching threshold.
//   Result channel (out_valid / out_stall / out_*) carries one item per finished
//   non-empty line or per line dropped as too long: status, parsed value and both
//   thresholds as they stand after that byte.
//   Each byte is parsed in the cycle it is accepted; its result is registered in
//   the output queue. One byte per cycle is sustained while in_stall is low: the
//   parse state registers are updated in a single pass per byte.
//   A two-entry output queue (result register plus skid register) lets bytes
//   keep flowing while a result waits; in_stall rises only when both entries
//   are full, i.e. after a second result while the receiver stalls.
//   Reset (rst_n low, synchronous) empties the queue, clears the line state and
//   sets the thresholds to 270 and 100.
`include "temp_limit_command_parser_defines.svh"

module temp_limit_command_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tlcp_pkg::DATA_W-1:0]   in_rx_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [tlcp_pkg::VAL_W-1:0]    out_parsed_value,
  output logic [tlcp_pkg::VAL_W-1:0]    out_max_limit,
  output logic [tlcp_pkg::VAL_W-1:0]    out_min_limit
);
  import tlcp_pkg::*;

  // Line state
  logic [LEN_W-1:0]  len_r, len_nxt;
  phase_t            phase_r, phase_nxt;
  logic [KIDX_W-1:0] kidx_r, kidx_nxt;
  logic [1:0]        cand_r, cand_nxt;
  logic [VAL_W-1:0]  acc_r, acc_nxt;
  logic              ended_r, ended_nxt;
  logic [VAL_W-1:0]  max_r, max_nxt;
  logic [VAL_W-1:0]  min_r, min_nxt;

  // Output queue
  logic              out_valid_r, out_valid_nxt;
  result_t           out_r, out_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  result_t           skid_r, skid_nxt;

  logic              accept;
  logic              res_fire;
  result_t           res;
  logic [DATA_W-1:0] c;
  logic              is_eol;
  logic [18:0]       acc_x10;
  logic [1:0]        cand_m;

  // Terms used by the checks
  logic              line_busy;
  logic              num_phase;
  logic              skid_drain;

  assign c        = in_rx_data;
  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !skid_valid_r;
  assign is_eol   = (c == CH_CR) || (c == CH_LF);
  assign acc_x10  = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1)
                  + {15'd0, c[3:0]};
  assign cand_m   = cand_r & kw_match(kidx_r, c);

  // Per-byte parse step
  always_comb begin
    len_nxt   = len_r;
    phase_nxt = phase_r;
    kidx_nxt  = kidx_r;
    cand_nxt  = cand_r;
    acc_nxt   = acc_r;
    ended_nxt = ended_r;
    max_nxt   = max_r;
    min_nxt   = min_r;
    res_fire  = 1'b0;
    res       = '{status: ST_UNKNOWN, value: '0, max_limit: max_r, min_limit: min_r};

    if (accept) begin
      if (is_eol) begin
        if (len_r != '0) begin
          res_fire = 1'b1;
          if (phase_r == PH_DIGITS || phase_r == PH_TRAIL) begin
            priority if (cand_r[0]) begin
              max_nxt    = acc_r;
              res.status = ST_MAX_SET;
              res.value  = acc_r;
            end else if (cand_r[1]) begin
              min_nxt    = acc_r;
              res.status = ST_MIN_SET;
              res.value  = acc_r;
            end
          end
          res.max_limit = max_nxt;
          res.min_limit = min_nxt;
          len_nxt   = '0;
          phase_nxt = PH_LEAD;
          kidx_nxt  = '0;
          cand_nxt  = CAND_BOTH;
          acc_nxt   = '0;
          ended_nxt = 1'b0;
        end
      end else if (len_r < LEN_W'(LINE_CAPACITY - 1)) begin
        len_nxt = len_r + 1'b1;
        if (!ended_r) begin
          if (c == CH_NUL) begin
            ended_nxt = 1'b1;
          end else begin
            unique case (phase_r)
              PH_LEAD, PH_KEY: begin
                if (phase_r == PH_LEAD && is_blank(c)) begin
                  phase_nxt = PH_LEAD;
                end else if (kidx_r >= KIDX_W'(KW_LEN)) begin
                  phase_nxt = PH_FAIL;
                end else begin
                  cand_nxt = cand_m;
                  if (cand_m == 2'b00) begin
                    phase_nxt = PH_FAIL;
                  end else begin
                    kidx_nxt  = kidx_r + 1'b1;
                    phase_nxt = (kidx_r == KIDX_W'(KW_LEN - 1)) ? PH_SEP : PH_KEY;
                  end
                end
              end
              PH_SEP: begin
                phase_nxt = is_blank(c) ? PH_GAP : PH_FAIL;
              end
              PH_GAP: begin
                if (is_digit(c)) begin
                  acc_nxt   = {11'd0, c[3:0]};
                  phase_nxt = PH_DIGITS;
                end else if (!is_blank(c)) begin
                  phase_nxt = PH_FAIL;
                end
              end
              PH_DIGITS: begin
                if (is_digit(c)) begin
                  if (acc_x10 > {4'd0, VALUE_MAX}) begin
                    phase_nxt = PH_FAIL;
                  end else begin
                    acc_nxt = acc_x10[VAL_W-1:0];
                  end
                end else if (is_blank(c)) begin
                  phase_nxt = PH_TRAIL;
                end else begin
                  phase_nxt = PH_FAIL;
                end
              end
              PH_TRAIL: begin
                if (!is_blank(c)) phase_nxt = PH_FAIL;
              end
              default: phase_nxt = PH_FAIL;
            endcase
          end
        end
      end else begin
        // line full: drop the byte and the line
        res_fire   = 1'b1;
        res.status = ST_TOO_LONG;
        len_nxt    = '0;
        phase_nxt  = PH_LEAD;
        kidx_nxt   = '0;
        cand_nxt   = CAND_BOTH;
        acc_nxt    = '0;
        ended_nxt  = 1'b0;
      end
    end
  end

  // Output queue: result register with a skid entry behind it
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (!out_stall) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_fire) begin
      if (!out_valid_r || !out_stall) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r        <= '0;
      phase_r      <= PH_LEAD;
      kidx_r       <= '0;
      cand_r       <= CAND_BOTH;
      acc_r        <= '0;
      ended_r      <= 1'b0;
      max_r        <= MAX_RESET_VAL;
      min_r        <= MIN_RESET_VAL;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      len_r        <= len_nxt;
      phase_r      <= phase_nxt;
      kidx_r       <= kidx_nxt;
      cand_r       <= cand_nxt;
      acc_r        <= acc_nxt;
      ended_r      <= ended_nxt;
      max_r        <= max_nxt;
      min_r        <= min_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Result payload registers
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_parsed_value = out_r.value;
  assign out_max_limit    = out_r.max_limit;
  assign out_min_limit    = out_r.min_limit;

  // Checks
  assign line_busy  = (phase_r != PH_LEAD) || ended_r;
  assign num_phase  = (phase_r == PH_DIGITS) || (phase_r == PH_TRAIL) || (phase_r == PH_GAP);
  assign skid_drain = skid_valid_r && !out_stall;

  `TLCP_ASSERT_IMPLY(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `TLCP_ASSERT_IMPLY(a_phase_needs_len, clk, rst_n, line_busy, len_r != '0)
  `TLCP_ASSERT_IMPLY(a_number_one_kw, clk, rst_n, num_phase, $onehot(cand_r))
  `TLCP_ASSERT_NEXT(a_full_stalls_drain, clk, rst_n, skid_drain, !skid_valid_r && out_valid_r)

endmodule
